// ===== sv/cbm_pkg.sv =====
package cbm_pkg;

  localparam int unsigned ROM_ADDR_W = 23;
  localparam int unsigned RAM_ADDR_W = 17;
  localparam int unsigned RAM_SIZE_W = 18;
  localparam int unsigned BANK_W     = 9;
  localparam int unsigned RAM_BANK_W = 4;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAPPER_KIND   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_SIZE      = 2'd2;

  localparam logic [7:0] OPEN_BUS_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    MAPPER_NONE = 2'd0,
    MAPPER_MBC1 = 2'd1,
    MAPPER_MBC3 = 2'd2,
    MAPPER_MBC5 = 2'd3
  } cbm_mapper_e;

  typedef enum logic [1:0] {
    ACCESS_NONE      = 2'd0,
    ACCESS_ROM_READ  = 2'd1,
    ACCESS_RAM_READ  = 2'd2,
    ACCESS_RAM_WRITE = 2'd3
  } cbm_access_e;

  typedef struct packed {
    cbm_mapper_e           mapper_kind;
    logic [BANK_W-1:0]     rom_bank_mask;
    logic [RAM_SIZE_W-1:0] ram_size_bytes;
  } cbm_cfg_t;

  typedef struct packed {
    logic                  ram_enabled;
    logic [BANK_W-1:0]     rom_bank_select;
    logic [RAM_BANK_W-1:0] ram_bank_select;
    logic                  banking_mode;
  } cbm_state_t;

  typedef struct packed {
    logic        opcode;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } cbm_req_t;

  typedef struct packed {
    cbm_access_e           access_kind;
    logic [ROM_ADDR_W-1:0] rom_byte_address;
    logic [RAM_ADDR_W-1:0] ram_byte_address;
    logic [7:0]            open_bus_data;
  } cbm_rsp_t;

endpackage

// ===== sv/cbm_req_if.sv =====
interface cbm_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] bus_address;
  logic [7:0]  write_data;

  modport source (output valid, opcode, bus_address, write_data, input ready);
  modport sink (input valid, opcode, bus_address, write_data, output ready);
endinterface

// ===== sv/cbm_rsp_if.sv =====
interface cbm_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      access_kind;
  logic [cbm_pkg::ROM_ADDR_W-1:0]  rom_byte_address;
  logic [cbm_pkg::RAM_ADDR_W-1:0]  ram_byte_address;
  logic [7:0]                      open_bus_data;

  modport source (output valid, access_kind, rom_byte_address, ram_byte_address,
                  open_bus_data, input ready);
  modport sink (input valid, access_kind, rom_byte_address, ram_byte_address,
                open_bus_data, output ready);
endinterface

// ===== sv/cbm_cfg_if.sv =====
interface cbm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cbm_pkg::CFG_IDX_W-1:0]   index;
  logic [cbm_pkg::RAM_SIZE_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/cbm_decode.sv =====
module cbm_decode #(
  parameter int unsigned ROM_ADDRESS_BITS = 23
) (
  input  cbm_pkg::cbm_cfg_t   cfg_i,
  input  cbm_pkg::cbm_state_t state_i,
  input  cbm_pkg::cbm_req_t   req_i,
  output cbm_pkg::cbm_state_t state_o,
  output cbm_pkg::cbm_rsp_t   rsp_o
);

  localparam logic [1:0] REGION_RAM_ENABLE = 2'd0;
  localparam logic [1:0] REGION_ROM_BANK   = 2'd1;
  localparam logic [1:0] REGION_RAM_BANK   = 2'd2;
  localparam logic [1:0] REGION_MODE       = 2'd3;

  localparam logic [cbm_pkg::ROM_ADDR_W-1:0] ROM_MASK =
    cbm_pkg::ROM_ADDR_W'((24'd1 << ROM_ADDRESS_BITS) - 24'd1);

  logic [cbm_pkg::BANK_W-1:0]     upper;
  logic [cbm_pkg::BANK_W-1:0]     bank;
  logic [cbm_pkg::RAM_ADDR_W-1:0] ram_off;
  logic                           ram_ok;
  logic [4:0]                     b5;
  logic [6:0]                     b7;
  logic [7:0]                     v;

  always_comb begin
    state_o = state_i;
    rsp_o = '0;
    rsp_o.access_kind = cbm_pkg::ACCESS_NONE;
    v = req_i.write_data;
    b5 = v[4:0];
    b7 = v[6:0];
    upper = {state_i.ram_bank_select, 5'b00000};
    bank = '0;
    ram_ok = 1'b0;
    if (state_i.banking_mode == 1'b0 && cfg_i.mapper_kind == cbm_pkg::MAPPER_MBC1) begin
      ram_off = {4'b0000, req_i.bus_address[12:0]};
    end else begin
      ram_off = {state_i.ram_bank_select, req_i.bus_address[12:0]};
    end

    if (!req_i.bus_address[15]) begin
      if (req_i.opcode == cbm_pkg::OP_WRITE) begin
        unique case (req_i.bus_address[14:13])
          REGION_RAM_ENABLE: begin
            state_o.ram_enabled = (v[3:0] == 4'hA);
          end
          REGION_ROM_BANK: begin
            case (cfg_i.mapper_kind)
              cbm_pkg::MAPPER_MBC1: begin
                state_o.rom_bank_select = {2'b00, state_i.rom_bank_select[6:5],
                                           (b5 == 5'd0) ? 5'd1 : b5};
              end
              cbm_pkg::MAPPER_MBC3: begin
                state_o.rom_bank_select = {2'b00, (b7 == 7'd0) ? 7'd1 : b7};
              end
              cbm_pkg::MAPPER_MBC5: begin
                // low byte at 0x2000-0x2fff, bit 8 at 0x3000-0x3fff
                if (req_i.bus_address[12]) begin
                  state_o.rom_bank_select = {v[0], state_i.rom_bank_select[7:0]};
                end else begin
                  state_o.rom_bank_select = {state_i.rom_bank_select[8], v};
                end
              end
              default: ;
            endcase
          end
          REGION_RAM_BANK: begin
            case (cfg_i.mapper_kind)
              cbm_pkg::MAPPER_MBC1: state_o.ram_bank_select = {2'b00, v[1:0]};
              cbm_pkg::MAPPER_MBC3,
              cbm_pkg::MAPPER_MBC5: state_o.ram_bank_select = v[3:0];
              default: ;
            endcase
          end
          REGION_MODE: begin
            if (cfg_i.mapper_kind == cbm_pkg::MAPPER_MBC1) begin
              state_o.banking_mode = v[0];
            end
          end
          default: ;
        endcase
      end else begin
        if (!req_i.bus_address[14]) begin
          if (cfg_i.mapper_kind == cbm_pkg::MAPPER_MBC1 && state_i.banking_mode) begin
            bank = upper & cfg_i.rom_bank_mask;
          end
        end else if (cfg_i.mapper_kind == cbm_pkg::MAPPER_MBC1) begin
          bank = (upper | {4'b0000, state_i.rom_bank_select[4:0]}) & cfg_i.rom_bank_mask;
        end else begin
          bank = state_i.rom_bank_select & cfg_i.rom_bank_mask;
        end
        rsp_o.access_kind = cbm_pkg::ACCESS_ROM_READ;
        rsp_o.rom_byte_address = {bank, req_i.bus_address[13:0]} & ROM_MASK;
      end
    end else begin
      ram_ok = state_i.ram_enabled && (cfg_i.ram_size_bytes != '0);
      // mbc3 rtc register selected: writes go nowhere
      if (req_i.opcode == cbm_pkg::OP_WRITE && cfg_i.mapper_kind == cbm_pkg::MAPPER_MBC3 &&
          state_i.ram_bank_select[3]) begin
        ram_ok = 1'b0;
      end
      if (ram_ok && ({1'b0, ram_off} < cfg_i.ram_size_bytes)) begin
        rsp_o.access_kind = (req_i.opcode == cbm_pkg::OP_WRITE) ?
                            cbm_pkg::ACCESS_RAM_WRITE : cbm_pkg::ACCESS_RAM_READ;
        rsp_o.ram_byte_address = ram_off;
      end else if (req_i.opcode == cbm_pkg::OP_READ) begin
        rsp_o.open_bus_data = cbm_pkg::OPEN_BUS_BYTE;
      end
    end
  end

endmodule

// ===== sv/cartridge_bank_mapper.sv =====
// pipeline: an input stage, then a result stage, between request accept and result valid
// throughput: one request per cycle unless the output stalls; the input stage doubles
// as a skid slot so one more request is taken while a result waits on the output
// reset (async, active low) clears valid flags, sets bank state to ram disabled,
// rom bank 1, ram bank 0, mode 0, and config registers to mapper none,
// rom bank mask 1, ram size 0; config writes are never stalled
module cartridge_bank_mapper #(
  parameter int unsigned ROM_ADDRESS_BITS = 23
) (
  input logic      clk_i,
  input logic      rst_ni,
  cbm_req_if.sink   req_i,
  cbm_rsp_if.source rsp_o,
  cbm_cfg_if.sink   cfg_i
);

  localparam logic [cbm_pkg::ROM_ADDR_W-1:0] ROM_MASK =
    cbm_pkg::ROM_ADDR_W'((24'd1 << ROM_ADDRESS_BITS) - 24'd1);

  cbm_pkg::cbm_cfg_t   cfg_q;
  cbm_pkg::cbm_state_t state_q;
  cbm_pkg::cbm_state_t state_d;
  cbm_pkg::cbm_req_t   s1_q;
  cbm_pkg::cbm_rsp_t   rsp_d;
  cbm_pkg::cbm_rsp_t   out_q;
  logic                s1_valid_q;
  logic                out_valid_q;
  logic                advance;
  logic                req_fire;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mapper_kind    <= cbm_pkg::MAPPER_NONE;
      cfg_q.rom_bank_mask  <= 9'd1;
      cfg_q.ram_size_bytes <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        cbm_pkg::CFG_MAPPER_KIND:
          cfg_q.mapper_kind <= cbm_pkg::cbm_mapper_e'(cfg_i.data[1:0]);
        cbm_pkg::CFG_ROM_BANK_MASK:
          cfg_q.rom_bank_mask <= cfg_i.data[cbm_pkg::BANK_W-1:0];
        cbm_pkg::CFG_RAM_SIZE:
          cfg_q.ram_size_bytes <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign advance     = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || advance;
  assign req_fire    = req_i.valid && req_i.ready;

  cbm_decode #(
    .ROM_ADDRESS_BITS(ROM_ADDRESS_BITS)
  ) u_decode (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .req_i   (s1_q),
    .state_o (state_d),
    .rsp_o   (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q              <= 1'b0;
      out_valid_q             <= 1'b0;
      state_q.ram_enabled     <= 1'b0;
      state_q.rom_bank_select <= 9'd1;
      state_q.ram_bank_select <= '0;
      state_q.banking_mode    <= 1'b0;
    end else begin
      if (req_fire) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_q.opcode      <= req_i.opcode;
      s1_q.bus_address <= req_i.bus_address;
      s1_q.write_data  <= req_i.write_data;
    end
    if (advance) begin
      out_q <= rsp_d;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.access_kind      = out_q.access_kind;
  assign rsp_o.rom_byte_address = out_q.rom_byte_address;
  assign rsp_o.ram_byte_address = out_q.ram_byte_address;
  assign rsp_o.open_bus_data    = out_q.open_bus_data;

`ifndef SYNTHESIS
  a_open_bus_only_on_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.access_kind != cbm_pkg::ACCESS_NONE |-> rsp_o.open_bus_data == 8'h00)
    else $error("open bus data on a mapped access");
  a_none_has_no_address: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.access_kind == cbm_pkg::ACCESS_NONE |->
    rsp_o.rom_byte_address == '0 && rsp_o.ram_byte_address == '0)
    else $error("address driven on an unmapped access");
  a_rom_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.rom_byte_address & ~ROM_MASK) == '0)
    else $error("rom address beyond rom address bits");
  a_request_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> s1_valid_q)
    else $error("accepted request lost");
  a_stalled_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !rsp_o.ready |=> s1_valid_q && out_valid_q)
    else $error("pipeline stage dropped while output stalled");
`endif

endmodule

// ===== test/cartridge_bank_mapper_test.sv =====
`timescale 1ns / 100ps

module cartridge_bank_mapper_test;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned PRINT_LIMIT = 40;
  localparam logic [cbm_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;

  cbm_req_if req_if ();
  cbm_rsp_if rsp_if ();
  cbm_cfg_if cfg_if ();

  cartridge_bank_mapper u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  always #6 clk_i = ~clk_i;

  // predictor copy of the mapper registers and bank state
  cbm_pkg::cbm_cfg_t   cart_cfg;
  cbm_pkg::cbm_state_t cart_state;

  cbm_pkg::cbm_req_t access_q[$];
  cbm_pkg::cbm_rsp_t mapped_q[$];

  cbm_pkg::cbm_req_t next_acc;
  cbm_pkg::cbm_req_t seen_acc;
  cbm_pkg::cbm_rsp_t want_rsp;
  logic     req_taken;
  int       error_count = 0;
  int       cycle_count = 0;
  int       burst_left = 0;
  int       idle_left = 0;
  int       stall_mode = 0;
  int       mode_left = 0;
  int       stall_hold = 0;
  logic     stall_level = 1'b1;

  function automatic cbm_pkg::cbm_rsp_t map_access(cbm_pkg::cbm_req_t acc);
    cbm_pkg::cbm_rsp_t              rsp;
    logic [cbm_pkg::BANK_W-1:0]     bank;
    logic [cbm_pkg::BANK_W-1:0]     upper;
    logic [cbm_pkg::RAM_ADDR_W-1:0] offset;
    logic [4:0]                     low5;
    logic [6:0]                     low7;
    logic                           ram_ok;
    rsp = '0;
    rsp.access_kind = cbm_pkg::ACCESS_NONE;
    if (!acc.bus_address[15]) begin
      if (acc.opcode == cbm_pkg::OP_WRITE) begin
        if (acc.bus_address < 16'h2000) begin
          cart_state.ram_enabled = (acc.write_data[3:0] == 4'hA);
        end else if (acc.bus_address < 16'h4000) begin
          case (cart_cfg.mapper_kind)
            cbm_pkg::MAPPER_MBC1: begin
              low5 = acc.write_data[4:0];
              cart_state.rom_bank_select = (cart_state.rom_bank_select & 9'h060) |
                                           ((low5 == '0) ? 9'd1 : {4'd0, low5});
            end
            cbm_pkg::MAPPER_MBC3: begin
              low7 = acc.write_data[6:0];
              cart_state.rom_bank_select = (low7 == '0) ? 9'd1 : {2'd0, low7};
            end
            cbm_pkg::MAPPER_MBC5: begin
              // low byte and ninth bit sit in separate halves of the window
              if (acc.bus_address < 16'h3000)
                cart_state.rom_bank_select = {cart_state.rom_bank_select[8], acc.write_data};
              else
                cart_state.rom_bank_select = {acc.write_data[0],
                                              cart_state.rom_bank_select[7:0]};
            end
            default: ;
          endcase
        end else if (acc.bus_address < 16'h6000) begin
          if (cart_cfg.mapper_kind == cbm_pkg::MAPPER_MBC1)
            cart_state.ram_bank_select = {2'b00, acc.write_data[1:0]};
          else if (cart_cfg.mapper_kind != cbm_pkg::MAPPER_NONE)
            cart_state.ram_bank_select = acc.write_data[3:0];
        end else if (cart_cfg.mapper_kind == cbm_pkg::MAPPER_MBC1) begin
          cart_state.banking_mode = acc.write_data[0];
        end
      end else begin
        upper = {cart_state.ram_bank_select, 5'd0};
        if (acc.bus_address < 16'h4000) begin
          bank = '0;
          if (cart_cfg.mapper_kind == cbm_pkg::MAPPER_MBC1 && cart_state.banking_mode)
            bank = upper & cart_cfg.rom_bank_mask;
        end else if (cart_cfg.mapper_kind == cbm_pkg::MAPPER_MBC1) begin
          bank = (upper | {4'd0, cart_state.rom_bank_select[4:0]}) & cart_cfg.rom_bank_mask;
        end else begin
          bank = cart_state.rom_bank_select & cart_cfg.rom_bank_mask;
        end
        rsp.rom_byte_address = {bank, acc.bus_address[13:0]};
        rsp.access_kind = cbm_pkg::ACCESS_ROM_READ;
      end
    end else begin
      ram_ok = cart_state.ram_enabled && (cart_cfg.ram_size_bytes != '0);
      if (cart_cfg.mapper_kind == cbm_pkg::MAPPER_MBC1 && !cart_state.banking_mode)
        offset = {4'd0, acc.bus_address[12:0]};
      else
        offset = {cart_state.ram_bank_select, acc.bus_address[12:0]};
      // rtc register selected: writes go nowhere, reads still pass
      if (acc.opcode == cbm_pkg::OP_WRITE && cart_cfg.mapper_kind == cbm_pkg::MAPPER_MBC3 &&
          cart_state.ram_bank_select >= 4'd8)
        ram_ok = 1'b0;
      if (ram_ok && offset < cart_cfg.ram_size_bytes) begin
        rsp.access_kind = (acc.opcode == cbm_pkg::OP_WRITE) ? cbm_pkg::ACCESS_RAM_WRITE
                                                            : cbm_pkg::ACCESS_RAM_READ;
        rsp.ram_byte_address = offset;
      end else if (acc.opcode == cbm_pkg::OP_READ) begin
        rsp.open_bus_data = cbm_pkg::OPEN_BUS_BYTE;
      end
    end
    return rsp;
  endfunction

  function automatic cbm_pkg::cbm_req_t random_access();
    cbm_pkg::cbm_req_t acc;
    int                pick;
    pick = $urandom_range(0, 99);
    acc.opcode = 1'($urandom_range(0, 1));
    acc.bus_address = 16'($urandom);
    acc.write_data = 8'($urandom);
    if (pick < 8) begin
      // plain noise
    end else if (pick < 14) begin
      acc.opcode = cbm_pkg::OP_WRITE;
      acc.bus_address = 16'($urandom_range(0, 16'h1FFF));
      if ($urandom_range(0, 3) != 0) acc.write_data[3:0] = 4'hA;
    end else if (pick < 24) begin
      acc.opcode = cbm_pkg::OP_WRITE;
      acc.bus_address = 16'($urandom_range(16'h2000, 16'h3FFF));
      if ($urandom_range(0, 5) == 0) acc.write_data = '0;
    end else if (pick < 30) begin
      acc.opcode = cbm_pkg::OP_WRITE;
      acc.bus_address = 16'($urandom_range(16'h4000, 16'h5FFF));
    end else if (pick < 34) begin
      acc.opcode = cbm_pkg::OP_WRITE;
      acc.bus_address = 16'($urandom_range(16'h6000, 16'h7FFF));
    end else if (pick < 60) begin
      acc.opcode = cbm_pkg::OP_READ;
      acc.bus_address = 16'($urandom_range(0, 16'h7FFF));
    end else begin
      acc.bus_address = 16'($urandom_range(16'h8000, 16'hFFFF));
    end
    return acc;
  endfunction

  task automatic queue_access(logic op, logic [15:0] addr, logic [7:0] data);
    cbm_pkg::cbm_req_t acc;
    acc.opcode = op;
    acc.bus_address = addr;
    acc.write_data = data;
    access_q.push_back(acc);
  endtask

  task automatic queue_random(int count);
    repeat (count) access_q.push_back(random_access());
  endtask

  task automatic write_config(logic [cbm_pkg::CFG_IDX_W-1:0] idx,
                              logic [cbm_pkg::RAM_SIZE_W-1:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      cbm_pkg::CFG_MAPPER_KIND:
        cart_cfg.mapper_kind = cbm_pkg::cbm_mapper_e'(value[1:0]);
      cbm_pkg::CFG_ROM_BANK_MASK:
        cart_cfg.rom_bank_mask = value[cbm_pkg::BANK_W-1:0];
      cbm_pkg::CFG_RAM_SIZE:
        cart_cfg.ram_size_bytes = value;
      default: ;
    endcase
  endtask

  // unused upper bits of the narrow registers get junk
  task automatic set_config(cbm_pkg::cbm_mapper_e kind, logic [cbm_pkg::BANK_W-1:0] mask,
                            logic [cbm_pkg::RAM_SIZE_W-1:0] size);
    logic [cbm_pkg::RAM_SIZE_W-1:0] value;
    value = cbm_pkg::RAM_SIZE_W'($urandom);
    value[1:0] = kind;
    write_config(cbm_pkg::CFG_MAPPER_KIND, value);
    value = cbm_pkg::RAM_SIZE_W'($urandom);
    value[cbm_pkg::BANK_W-1:0] = mask;
    write_config(cbm_pkg::CFG_ROM_BANK_MASK, value);
    write_config(cbm_pkg::CFG_RAM_SIZE, size);
    if ($urandom_range(0, 1) != 0)
      write_config(CFG_SPARE_IDX, cbm_pkg::RAM_SIZE_W'($urandom));
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain_accesses();
    while (access_q.size() != 0 || req_if.valid || mapped_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic flag_mismatch(string what);
    if (error_count < PRINT_LIMIT) $display("%0t ns: mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // request driver: bursts separated by random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.opcode <= cbm_pkg::OP_READ;
      req_if.bus_address <= '0;
      req_if.write_data <= '0;
    end else if (!req_if.valid || req_taken) begin
      if (idle_left > 0 || access_q.size() == 0) begin
        req_if.valid <= 1'b0;
        if (idle_left > 0) idle_left--;
      end else begin
        next_acc = access_q.pop_front();
        req_if.valid <= 1'b1;
        req_if.opcode <= next_acc.opcode;
        req_if.bus_address <= next_acc.bus_address;
        req_if.write_data <= next_acc.write_data;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(0, 30);
          idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // result backpressure: always ready, random, or long on/off runs
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(50, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: rsp_if.ready <= 1'b1;
      1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_hold == 0) begin
          stall_hold = $urandom_range(1, 12);
          stall_level = ~stall_level;
        end else begin
          stall_hold--;
        end
        rsp_if.ready <= stall_level;
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) begin
        seen_acc.opcode = req_if.opcode;
        seen_acc.bus_address = req_if.bus_address;
        seen_acc.write_data = req_if.write_data;
        mapped_q.push_back(map_access(seen_acc));
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (mapped_q.size() == 0) begin
          flag_mismatch("result with no request outstanding");
        end else begin
          want_rsp = mapped_q.pop_front();
          if (rsp_if.access_kind !== want_rsp.access_kind)
            flag_mismatch($sformatf("access_kind %0d, expected %0d",
                                    rsp_if.access_kind, want_rsp.access_kind));
          if (rsp_if.rom_byte_address !== want_rsp.rom_byte_address)
            flag_mismatch($sformatf("rom_byte_address %h, expected %h",
                                    rsp_if.rom_byte_address, want_rsp.rom_byte_address));
          if (rsp_if.ram_byte_address !== want_rsp.ram_byte_address)
            flag_mismatch($sformatf("ram_byte_address %h, expected %h",
                                    rsp_if.ram_byte_address, want_rsp.ram_byte_address));
          if (rsp_if.open_bus_data !== want_rsp.open_bus_data)
            flag_mismatch($sformatf("open_bus_data %h, expected %h",
                                    rsp_if.open_bus_data, want_rsp.open_bus_data));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cartridge_bank_mapper_test: errors");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = cbm_pkg::CFG_MAPPER_KIND;
    cfg_if.data = '0;
    cart_cfg = '{cbm_pkg::MAPPER_NONE, 9'd1, 18'd0};
    cart_state = '{1'b0, 9'd1, 4'd0, 1'b0};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration: no mapper, two banks, no ram
    queue_access(cbm_pkg::OP_READ, 16'h0000, 8'h00);
    queue_access(cbm_pkg::OP_READ, 16'h7FFF, 8'h00);
    queue_access(cbm_pkg::OP_WRITE, 16'h2000, 8'h00);
    queue_access(cbm_pkg::OP_READ, 16'h4000, 8'h00);
    queue_access(cbm_pkg::OP_WRITE, 16'h0000, 8'h0A);
    queue_access(cbm_pkg::OP_READ, 16'h8000, 8'h00);
    queue_access(cbm_pkg::OP_WRITE, 16'hFFFF, 8'hFF);
    queue_random(60);
    drain_accesses();

    set_config(cbm_pkg::MAPPER_MBC1, 9'd511, 18'h20000);
    queue_access(cbm_pkg::OP_WRITE, 16'h2000, 8'h00);
    queue_access(cbm_pkg::OP_WRITE, 16'h4000, 8'h03);
    queue_access(cbm_pkg::OP_WRITE, 16'h6000, 8'h01);
    queue_access(cbm_pkg::OP_READ, 16'h0000, 8'h00);
    queue_access(cbm_pkg::OP_READ, 16'h7FFF, 8'h00);
    queue_access(cbm_pkg::OP_READ, 16'hBFFF, 8'h00);
    queue_access(cbm_pkg::OP_WRITE, 16'hA123, 8'h55);
    queue_access(cbm_pkg::OP_WRITE, 16'h6000, 8'h00);
    queue_access(cbm_pkg::OP_READ, 16'hA000, 8'h00);
    queue_access(cbm_pkg::OP_WRITE, 16'h3FFF, 8'hE0);
    queue_access(cbm_pkg::OP_READ, 16'h4000, 8'h00);
    queue_access(cbm_pkg::OP_WRITE, 16'h1FFF, 8'h0B);
    queue_access(cbm_pkg::OP_READ, 16'hA000, 8'h00);
    queue_random(150);
    drain_accesses();

    set_config(cbm_pkg::MAPPER_MBC3, 9'd127, 18'h20000);
    queue_access(cbm_pkg::OP_WRITE, 16'h0000, 8'h1A);
    queue_access(cbm_pkg::OP_WRITE, 16'h4000, 8'h08);
    queue_access(cbm_pkg::OP_WRITE, 16'hA000, 8'h77);
    queue_access(cbm_pkg::OP_READ, 16'hA000, 8'h00);
    queue_access(cbm_pkg::OP_WRITE, 16'h2000, 8'h80);
    queue_access(cbm_pkg::OP_READ, 16'h4000, 8'h00);
    queue_random(150);
    drain_accesses();

    set_config(cbm_pkg::MAPPER_MBC5, 9'd511, 18'h08000);
    queue_random(150);
    drain_accesses();

    set_config(cbm_pkg::MAPPER_MBC1, 9'd0, 18'h02000);
    queue_random(120);
    drain_accesses();

    // bank state left over from the mbc1 phase is read by the new rules
    set_config(cbm_pkg::MAPPER_NONE, 9'd511, 18'h3FFFF);
    queue_random(120);
    drain_accesses();

    set_config(cbm_pkg::MAPPER_MBC3, 9'd63, 18'd2000);
    queue_random(120);
    drain_accesses();

    set_config(cbm_pkg::MAPPER_MBC5, cbm_pkg::BANK_W'($urandom_range(0, 511)),
               cbm_pkg::RAM_SIZE_W'($urandom_range(1, 18'h20000)));
    queue_random(100);
    drain_accesses();

    set_config(cbm_pkg::MAPPER_MBC1, 9'd31, 18'h08000);
    queue_random(100);
    drain_accesses();

    set_config(cbm_pkg::MAPPER_MBC3, 9'd511, 18'd0);
    queue_random(100);
    drain_accesses();

    set_config(cbm_pkg::MAPPER_MBC5, 9'd1, 18'h1FFFF);
    queue_random(120);
    drain_accesses();

    if (error_count == 0) begin
      $display("cartridge_bank_mapper_test: clean");
    end else begin
      $display("cartridge_bank_mapper_test: errors");
    end
    $finish;
  end

endmodule
